### rtl/core/perx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition extent read splitter package
// Shared types and constants for the extent table and the request sequencer.
// ----------------------------------------------------------------------------
package perx_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned BLK_W        = 23;
  localparam int unsigned SECTOR_SHIFT = 11;
  localparam int unsigned BLOCK_SHIFT  = 2;
  // sectors in one chunk fit the partition length in sectors
  localparam int unsigned N_W          = DATA_W - SECTOR_SHIFT;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_CHUNK = 2'd0,
    STATUS_DONE  = 2'd1,
    STATUS_MISS  = 2'd2
  } status_e;

  typedef struct packed {
    logic [DATA_W-1:0] start_lsn;
    logic [DATA_W-1:0] size_bytes;
    logic [DATA_W-1:0] lba_base;
  } entry_t;

endpackage

### rtl/core/perx_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying table loads and read requests.
// ----------------------------------------------------------------------------
interface perx_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  entry_index;
  logic [31:0] entry_start_lsn;
  logic [31:0] entry_size_bytes;
  logic [31:0] entry_lba_base;
  logic [31:0] req_lsn;
  logic [31:0] req_sectors;

  modport source (
    output valid, op, entry_index, entry_start_lsn, entry_size_bytes,
           entry_lba_base, req_lsn, req_sectors,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, entry_start_lsn, entry_size_bytes,
           entry_lba_base, req_lsn, req_sectors,
    output ready
  );
endinterface

### rtl/core/perx_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying disk commands and end-of-request results.
// ----------------------------------------------------------------------------
interface perx_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] lba;
  logic [22:0] block_count;
  logic [31:0] buffer_offset;
  logic [1:0]  status;
  logic        last;

  modport source (
    output valid, lba, block_count, buffer_offset, status, last,
    input  ready
  );

  modport sink (
    input  valid, lba, block_count, buffer_offset, status, last,
    output ready
  );
endinterface

### rtl/core/perx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module perx_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/perx_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent table
// Extent RAM with per-entry valid bits; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module perx_table
  import perx_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  logic [ENTRIES-1:0] valid_q;
  logic               rvalid_q;
  entry_t             ram_rdata;

  perx_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? ram_rdata : '0;

endmodule

### rtl/core/perx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request sequencer
// Loads table entries, walks read requests through the table and emits
// one disk command per partition run followed by an end result.
// ----------------------------------------------------------------------------
module perx_ctrl
  import perx_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int unsigned CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] limit_i,
  perx_req_if.sink         req_i,
  perx_rsp_if.source       rsp_o,
  output logic             tbl_we_o,
  output logic [IDX_W-1:0] tbl_waddr_o,
  output entry_t           tbl_wdata_o,
  output logic [IDX_W-1:0] tbl_raddr_o,
  input  entry_t           tbl_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CUR_WAIT,
    S_CUR_EVAL,
    S_SCAN_WAIT,
    S_SCAN_EVAL,
    S_SIZE,
    S_EMIT,
    S_FINISH
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  cur_q;
  logic [IDX_W-1:0]  scan_q;
  logic [CNT_W-1:0]  k_q;
  logic [DATA_W-1:0] cursor_q;
  logic [DATA_W-1:0] remaining_q;
  logic [DATA_W-1:0] offset_q;
  logic [DATA_W-1:0] start_q;
  logic [DATA_W-1:0] base_q;
  logic [DATA_W-1:0] end_q;
  logic              cov_q;
  logic [N_W-1:0]    n_q;
  logic [DATA_W-1:0] rel_q;
  status_e           status_q;

  logic              rsp_valid_q;
  logic [DATA_W-1:0] rsp_lba_q;
  logic [BLK_W-1:0]  rsp_blk_q;
  logic [DATA_W-1:0] rsp_off_q;
  status_e           rsp_status_q;
  logic              rsp_last_q;

  logic              req_fire;
  logic              slot_ok;
  logic              out_free;
  logic              rsp_load;
  logic [DATA_W-1:0] rd_end;
  logic              rd_cov;
  logic [DATA_W-1:0] diff;
  logic [CNT_W-1:0]  scan_next;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_ok     = (32'(req_i.entry_index) < ENTRIES);
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign rsp_load    = out_free && ((state_q == S_EMIT) || (state_q == S_FINISH));

  assign tbl_we_o    = req_fire && (req_i.op == OP_LOAD) && slot_ok;
  assign tbl_waddr_o = IDX_W'(req_i.entry_index);
  assign tbl_wdata_o = '{start_lsn:  req_i.entry_start_lsn,
                         size_bytes: req_i.entry_size_bytes,
                         lba_base:   req_i.entry_lba_base};

  assign scan_next = CNT_W'(scan_q) + CNT_W'(1);

  always_comb begin
    case (state_q)
      S_CUR_EVAL:  tbl_raddr_o = '0;
      S_SCAN_EVAL: tbl_raddr_o = IDX_W'(scan_next);
      default:     tbl_raddr_o = cur_q;
    endcase
  end

  // entry end wraps; a wrapped or empty entry covers nothing
  assign rd_end = tbl_rdata_i.start_lsn +
                  {{SECTOR_SHIFT{1'b0}}, tbl_rdata_i.size_bytes[DATA_W-1:SECTOR_SHIFT]};
  assign rd_cov = (cursor_q >= tbl_rdata_i.start_lsn) && (cursor_q < rd_end);
  assign diff   = end_q - cursor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      scan_q       <= '0;
      k_q          <= '0;
      cursor_q     <= '0;
      remaining_q  <= '0;
      offset_q     <= '0;
      start_q      <= '0;
      base_q       <= '0;
      end_q        <= '0;
      cov_q        <= 1'b0;
      n_q          <= '0;
      rel_q        <= '0;
      status_q     <= STATUS_DONE;
      rsp_valid_q  <= 1'b0;
      rsp_lba_q    <= '0;
      rsp_blk_q    <= '0;
      rsp_off_q    <= '0;
      rsp_status_q <= STATUS_CHUNK;
      rsp_last_q   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire && (req_i.op == OP_READ)) begin
            cursor_q    <= req_i.req_lsn;
            remaining_q <= req_i.req_sectors;
            offset_q    <= '0;
            k_q         <= '0;
            state_q     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((remaining_q == '0) || (k_q == CNT_W'(ENTRIES))) begin
            status_q <= STATUS_DONE;
            state_q  <= S_FINISH;
          end else begin
            state_q <= S_CUR_WAIT;
          end
        end
        S_CUR_WAIT, S_SCAN_WAIT: begin
          start_q <= tbl_rdata_i.start_lsn;
          base_q  <= tbl_rdata_i.lba_base;
          end_q   <= rd_end;
          cov_q   <= rd_cov;
          state_q <= (state_q == S_CUR_WAIT) ? S_CUR_EVAL : S_SCAN_EVAL;
        end
        S_CUR_EVAL: begin
          if (cov_q) begin
            state_q <= S_SIZE;
          end else if (limit_i == '0) begin
            status_q <= STATUS_MISS;
            state_q  <= S_FINISH;
          end else begin
            scan_q  <= '0;
            state_q <= S_SCAN_WAIT;
          end
        end
        S_SCAN_EVAL: begin
          if (cov_q) begin
            cur_q   <= scan_q;
            state_q <= S_SIZE;
          end else if (scan_next < limit_i) begin
            scan_q  <= IDX_W'(scan_next);
            state_q <= S_SCAN_WAIT;
          end else begin
            status_q <= STATUS_MISS;
            state_q  <= S_FINISH;
          end
        end
        S_SIZE: begin
          n_q     <= (remaining_q < diff) ? N_W'(remaining_q) : N_W'(diff);
          rel_q   <= cursor_q - start_q;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_lba_q    <= base_q + {rel_q[DATA_W-BLOCK_SHIFT-1:0], {BLOCK_SHIFT{1'b0}}};
            rsp_blk_q    <= {n_q, {BLOCK_SHIFT{1'b0}}};
            rsp_off_q    <= offset_q;
            rsp_status_q <= STATUS_CHUNK;
            rsp_last_q   <= 1'b0;
            offset_q     <= offset_q + {n_q, {SECTOR_SHIFT{1'b0}}};
            remaining_q  <= remaining_q - DATA_W'(n_q);
            cursor_q     <= cursor_q + DATA_W'(n_q);
            k_q          <= k_q + CNT_W'(1);
            state_q      <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp_lba_q    <= '0;
            rsp_blk_q    <= '0;
            rsp_off_q    <= offset_q;
            rsp_status_q <= status_q;
            rsp_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.lba           = rsp_lba_q;
  assign rsp_o.block_count   = rsp_blk_q;
  assign rsp_o.buffer_offset = rsp_off_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.last          = rsp_last_q;

  a_chunk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= CNT_W'(ENTRIES))
    else $error("chunk count exceeds table size");

  a_chunk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q == STATUS_CHUNK)) |-> (rsp_blk_q != '0))
    else $error("empty chunk command");

  a_last_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_last_q == (rsp_status_q != STATUS_CHUNK)))
    else $error("last flag disagrees with status");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_EVAL) |-> (CNT_W'(scan_q) < limit_i))
    else $error("scan beyond searched entries");

endmodule

### rtl/core/partition_extent_read_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition extent read splitter
// Translates logical sector reads into per-partition disk commands.
// ----------------------------------------------------------------------------
// Load transaction: table write in the accept cycle.
// Read transaction: CHECK, CUR_WAIT, CUR_EVAL, SIZE and EMIT per chunk when
//   the current partition hits, plus SCAN_WAIT and SCAN_EVAL per table
//   entry scanned on a miss (single table read port); end result via FINISH.
// One transaction in flight; the next is taken once the end result is queued.
// Reset: table reads as zero, num_parts and current partition are zero.
module partition_extent_read_splitter
  import perx_pkg::*;
#(
  parameter int unsigned PART_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  perx_req_if.sink         req_i,
  perx_rsp_if.source       rsp_o
);

  localparam int unsigned IDX_W = (PART_ENTRIES > 1) ? $clog2(PART_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(PART_ENTRIES + 1);

  logic [CFG_W-1:0] num_parts_q;
  logic [CNT_W-1:0] limit;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  entry_t           tbl_wdata;
  logic [IDX_W-1:0] tbl_raddr;
  entry_t           tbl_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_parts_q <= '0;
    end else if (cfg_we_i) begin
      num_parts_q <= cfg_wdata_i;
    end
  end

  assign limit = (32'(num_parts_q) >= PART_ENTRIES) ? CNT_W'(PART_ENTRIES)
                                                    : CNT_W'(num_parts_q);

  perx_table #(
    .ENTRIES (PART_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  perx_ctrl #(
    .ENTRIES (PART_ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata)
  );

endmodule

### tb/extent_split_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent split checker
// Watches the request, response and config ports of the splitter. Keeps its
// own copy of the extent table, the current partition and num_parts, works
// out the disk commands for every read transaction and compares each
// response transaction in order, field by field.
// ----------------------------------------------------------------------------
module extent_split_checker
  import perx_pkg::*;
#(
  parameter int unsigned PART_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  perx_req_if              req_i,
  perx_rsp_if              rsp_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] lba;
    logic [BLK_W-1:0]  blocks;
    logic [DATA_W-1:0] offset;
    status_e           status;
    logic              last;
  } disk_cmd_t;

  entry_t           extent_tab [PART_ENTRIES];
  logic [SLOT_W-1:0] cur_part;
  logic [CFG_W-1:0]  parts_cfg;
  disk_cmd_t         cmd_q [$];
  int unsigned       rsp_seen;

  task automatic report(input string msg);
    if (fail_count_o < 40) $display("%0t ERROR: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got,
                           input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %h, expected %h", rsp_seen, name, got, want));
  endtask

  function automatic logic [DATA_W-1:0] span_end(input int unsigned idx);
    return extent_tab[idx].start_lsn + (extent_tab[idx].size_bytes >> SECTOR_SHIFT);
  endfunction

  function automatic bit holds_lsn(input int unsigned idx, input logic [DATA_W-1:0] lsn);
    return (lsn >= extent_tab[idx].start_lsn) && (lsn < span_end(idx));
  endfunction

  task automatic predict_read(input logic [DATA_W-1:0] lsn_in,
                              input logic [DATA_W-1:0] count_in);
    logic [DATA_W-1:0] cursor, left, offs, n, scaled;
    int unsigned       lim, chunks, i;
    bit                hit, missed;
    disk_cmd_t         cmd;
    cursor = lsn_in;
    left   = count_in;
    offs   = '0;
    chunks = 0;
    missed = 1'b0;
    lim    = (parts_cfg < PART_ENTRIES) ? parts_cfg : PART_ENTRIES;
    while (left != 0 && chunks < PART_ENTRIES && !missed) begin
      // current partition first, then first hit below num_parts
      if (!holds_lsn(cur_part, cursor)) begin
        hit = 1'b0;
        for (i = 0; i < lim && !hit; i++) begin
          if (holds_lsn(i, cursor)) begin
            cur_part = SLOT_W'(i);
            hit = 1'b1;
          end
        end
        missed = !hit;
      end
      if (!missed) begin
        n = span_end(cur_part) - cursor;
        if (left < n) n = left;
        scaled     = n << BLOCK_SHIFT;
        cmd.lba    = extent_tab[cur_part].lba_base +
                     ((cursor - extent_tab[cur_part].start_lsn) << BLOCK_SHIFT);
        cmd.blocks = scaled[BLK_W-1:0];
        cmd.offset = offs;
        cmd.status = STATUS_CHUNK;
        cmd.last   = 1'b0;
        cmd_q.push_back(cmd);
        chunks++;
        offs   += n << SECTOR_SHIFT;
        left   -= n;
        cursor += n;
      end
    end
    cmd.lba    = '0;
    cmd.blocks = '0;
    cmd.offset = offs;
    cmd.status = missed ? STATUS_MISS : STATUS_DONE;
    cmd.last   = 1'b1;
    cmd_q.push_back(cmd);
  endtask

  task automatic check_cmd();
    disk_cmd_t want;
    if (cmd_q.size() == 0) begin
      report($sformatf("unexpected result lba=%h status=%0d", rsp_i.lba, rsp_i.status));
    end else begin
      want = cmd_q.pop_front();
      cmp_field("lba", rsp_i.lba, want.lba);
      cmp_field("block_count", 32'(rsp_i.block_count), 32'(want.blocks));
      cmp_field("buffer_offset", rsp_i.buffer_offset, want.offset);
      cmp_field("status", 32'(rsp_i.status), 32'(want.status));
      cmp_field("last", 32'(rsp_i.last), 32'(want.last));
    end
    rsp_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PART_ENTRIES; k++) extent_tab[k] = '0;
      cur_part = '0;
      parts_cfg = '0;
      cmd_q.delete();
      fail_count_o = 0;
      rsp_seen = 0;
    end else begin
      if (cfg_we_i) parts_cfg = cfg_wdata_i;
      if (rsp_i.valid && rsp_i.ready) check_cmd();
      if (req_i.valid && req_i.ready) begin
        if (req_i.op == OP_LOAD) begin
          if (req_i.entry_index < PART_ENTRIES) begin
            extent_tab[req_i.entry_index].start_lsn  = req_i.entry_start_lsn;
            extent_tab[req_i.entry_index].size_bytes = req_i.entry_size_bytes;
            extent_tab[req_i.entry_index].lba_base   = req_i.entry_lba_base;
          end
        end else begin
          predict_read(req_i.req_lsn, req_i.req_sectors);
        end
      end
    end
    pending_o = cmd_q.size();
  end

endmodule

### tb/partition_extent_read_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition extent read splitter testbench
// Drives table loads and read requests with random stalls on both channels,
// changes num_parts between idle phases and leaves all checking to the
// extent split checker. Directed corner cases come first, then phases of mostly
// contiguous partition layouts with random reads and some noise.
// ----------------------------------------------------------------------------
module partition_extent_read_splitter_tb
  import perx_pkg::*;
();

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      fail_cnt;
  int unsigned      pending_cnt;
  int               req_idle_pct;
  int               rsp_idle_pct;

  perx_req_if req_ch ();
  perx_rsp_if rsp_ch ();

  partition_extent_read_splitter #(.PART_ENTRIES(16)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  extent_split_checker #(.PART_ENTRIES(16)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .fail_count_o(fail_cnt),
    .pending_o   (pending_cnt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("partition_extent_read_splitter verification failed");
    $finish;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(99, 0) < rsp_idle_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(7, 1)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic push_req(input op_e op, input logic [3:0] slot,
                          input logic [31:0] start, input logic [31:0] size,
                          input logic [31:0] base, input logic [31:0] lsn,
                          input logic [31:0] cnt);
    if ($urandom_range(99, 0) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.op               <= op;
    req_ch.entry_index      <= slot;
    req_ch.entry_start_lsn  <= start;
    req_ch.entry_size_bytes <= size;
    req_ch.entry_lba_base   <= base;
    req_ch.req_lsn          <= lsn;
    req_ch.req_sectors      <= cnt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic load_entry(input logic [3:0] slot, input logic [31:0] start,
                            input logic [31:0] size, input logic [31:0] base);
    push_req(OP_LOAD, slot, start, size, base, $urandom, $urandom);
  endtask

  task automatic read_span(input logic [31:0] lsn, input logic [31:0] cnt);
    push_req(OP_READ, 4'($urandom_range(15, 0)), $urandom, $urandom, $urandom, lsn, cnt);
  endtask

  // wait for the last result, then let trailing loads finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_parts(input int unsigned parts);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(parts);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int          perm [16];
    int          ph, k, r, j, tmp, nslots, wait_cnt;
    logic [31:0] area, pos, span, off, cnt, secs;

    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    req_ch.valid            <= 1'b0;
    req_ch.op               <= OP_LOAD;
    req_ch.entry_index      <= '0;
    req_ch.entry_start_lsn  <= '0;
    req_ch.entry_size_bytes <= '0;
    req_ch.entry_lba_base   <= '0;
    req_ch.req_lsn          <= '0;
    req_ch.req_sectors      <= '0;
    req_idle_pct = 20;
    rsp_idle_pct = 20;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, num_parts zero: miss, then zero-length request
    read_span(32'd0, 32'd5);
    read_span(32'd0, 32'd0);
    set_parts(16);
    load_entry(4'd0, 32'd100, (32'd4 << 11) | 32'h7FF, 32'h0000_1000);
    load_entry(4'd1, 32'd104, 32'd3 << 11, 32'hFFFF_FFF8);
    load_entry(4'd15, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h1234_5678);  // end wraps
    load_entry(4'd7, 32'd200, 32'h0000_07FF, 32'h0000_0040);         // under one sector
    load_entry(4'd3, 32'd110, 32'd2 << 11, 32'h0000_0020);           // hole before it
    read_span(32'd100, 32'd7);
    read_span(32'd101, 32'd20);
    read_span(32'hFFFF_FFF5, 32'd1);
    read_span(32'd200, 32'd1);
    read_span(32'd110, 32'hFFFF_FFFF);
    load_entry(4'd10, 32'h8000_0000, 32'hFFFF_F800, 32'hFFFF_FFFF);
    read_span(32'h8000_0000, 32'hFFFF_FFFF);
    // current partition lies beyond num_parts
    set_parts(2);
    read_span(32'h8000_0010, 32'd4);
    read_span(32'd100, 32'd1);
    read_span(32'd110, 32'd1);
    load_entry(4'd15, 32'd0, 32'hFFFF_FFFF, 32'd0);
    set_parts(16);
    read_span(32'd0, 32'h0020_0000);
    read_span(32'hFFFF_FFFF, 32'd1);

    for (ph = 0; ph < 8; ph++) begin
      case ($urandom_range(2, 0))
        0: req_idle_pct = 0;
        1: req_idle_pct = 15;
        default: req_idle_pct = 40;
      endcase
      case ($urandom_range(2, 0))
        0: rsp_idle_pct = 0;
        1: rsp_idle_pct = 10;
        default: rsp_idle_pct = 30;
      endcase
      if (ph == 7) begin
        req_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      if (ph == 0 || ph == 7) set_parts(16);
      else if (ph == 1) set_parts(0);
      else set_parts($urandom_range(16, 1));

      for (k = 0; k < 16; k++) perm[k] = k;
      for (k = 15; k > 0; k--) begin
        j = $urandom_range(k, 0);
        tmp = perm[k];
        perm[k] = perm[j];
        perm[j] = tmp;
      end
      nslots = (ph == 3) ? 16 : $urandom_range(8, 3);
      area = $urandom_range(32'hFFFF_FF00, 0);
      pos = area;
      for (k = 0; k < nslots; k++) begin
        if ($urandom_range(4, 0) == 0) pos += $urandom_range(3, 1);
        secs = $urandom_range(12, 1);
        load_entry(4'(perm[k]), pos, (secs << 11) | $urandom_range(2047, 0), $urandom);
        pos += secs;
      end
      span = pos - area;

      for (r = 0; r < 15; r++) begin
        if ($urandom_range(9, 0) < 7) begin
          off = $urandom_range(span - 1, 0);
          case ($urandom_range(9, 0))
            0: cnt = 32'd0;
            1: cnt = $urandom;
            default: cnt = $urandom_range(span - off + 2, 1);
          endcase
          read_span(area + off, cnt);
        end else if ($urandom_range(1, 0) == 0) begin
          load_entry(4'($urandom_range(15, 0)), $urandom, $urandom, $urandom);
        end else begin
          read_span($urandom, $urandom);
        end
      end
    end

    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    wait_cnt = 0;
    while (pending_cnt != 0 && wait_cnt < 50000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (16) @(posedge clk);
    if (pending_cnt != 0)
      $display("ERROR: %0d expected results never arrived", pending_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("partition_extent_read_splitter verification clean");
    end else begin
      $display("partition_extent_read_splitter verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/perx_pkg.sv
rtl/core/perx_req_if.sv
rtl/core/perx_rsp_if.sv
rtl/core/perx_ram.sv
rtl/core/perx_table.sv
rtl/core/perx_ctrl.sv
rtl/core/partition_extent_read_splitter.sv
tb/extent_split_checker.sv
tb/partition_extent_read_splitter_tb.sv
